// ===== rtl/bnl_pkg.sv =====
// ============================================================================
// bnl_pkg
// Shared types, codes and constants for the binary 3x3 neighbourhood lookup.
// ============================================================================
package bnl_pkg;

    // default bounds of the frame geometry
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DIM_RESET      = 2048;
    localparam int DIM_FIELD_W    = 12;

    // lookup table
    localparam int TABLE_DEPTH = 512;
    localparam int IDX_W       = 9;
    localparam int PIX_W       = 8;

    // input item kinds
    localparam logic [1:0] KIND_TABLE = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    // configuration register map
    localparam int         PADDR_W          = 4;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PAD_BIT      = 2'd2;

    // border masks over the column-major window index
    localparam logic [IDX_W-1:0] MASK_TOP    = 9'h049;
    localparam logic [IDX_W-1:0] MASK_BOTTOM = 9'h124;
    localparam logic [IDX_W-1:0] MASK_LEFT   = 9'h007;
    localparam logic [IDX_W-1:0] MASK_RIGHT  = 9'h1C0;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;
    localparam int OUTST_W    = FIFO_CNT_W + 1;

    // where the output position lies relative to the frame border
    typedef struct packed {
        logic emit;
        logic first_row;
        logic last_row;
        logic first_col;
        logic last_col;
        logic last;
    } t_pos;

    typedef struct packed {
        logic             frame_last;
        logic [PIX_W-1:0] result_pixel;
    } t_result;

    // 0 counts as 1, anything above the maximum saturates
    function automatic int clamp_dim(input logic [DIM_FIELD_W-1:0] v, input int maxv);
        int x;
        x = int'(v);
        if (x < 1) begin
            x = 1;
        end else if (x > maxv) begin
            x = maxv;
        end
        return x;
    endfunction

endpackage

// ===== rtl/bnl_if.sv =====
// ============================================================================
// bnl_if
// Valid/ready stream interfaces for input items and result items.
// ============================================================================
interface bnl_in_if import bnl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic [PIX_W-1:0]        pixel;
    logic [IDX_W-1:0]        table_index;
    logic [PIX_W-1:0]        table_value;

    modport source (output valid, kind, pixel, table_index, table_value, input ready);
    modport sink   (input valid, kind, pixel, table_index, table_value, output ready);
endinterface

interface bnl_out_if import bnl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] result_pixel;
    logic             frame_last;

    modport source (output valid, result_pixel, frame_last, input ready);
    modport sink   (input valid, result_pixel, frame_last, output ready);
endinterface

// ===== rtl/binary_3x3_neighborhood_lut.sv =====
// ============================================================================
// binary_3x3_neighborhood_lut
// Streaming 3x3 binary neighbourhood classifier feeding a 512-entry table.
// ============================================================================
// Usage:
//   i_in carries one transaction per item: kind 0 loads table_value into
//   table entry table_index, kind 1 is a pixel (nonzero = set), kind 2 is a
//   flush tick, kind 3 is dropped. o_out gives one transaction per output
//   pixel with frame_last on the final pixel of the frame. Each frame needs
//   frame_width+1 flushes after its last pixel to drain the bottom row.
//   Registers over APB: frame_width at 0x0, frame_height at 0x4, pad_bit at
//   0x8; write them only while the block is idle. A dimension write restarts
//   the frame.
// Throughput: one transaction per clock while i_in.ready is high, set by the
//   single read-modify-write of the line buffer per item and one table read per result.
// Pipeline: the transaction that completes a neighbourhood passes the line
//   buffer read, then the table read, then the result queue, before o_out offers the result.
// Reset: counters, window and queue clear; registers return to 2048 x 2048
//   (clamped to the maxima) and pad 0. Table and line buffer are not
//   cleared; the table must be loaded before use.
// Stall: a four-deep result queue absorbs a stalled receiver; i_in.ready
//   drops once the queue plus the two pipeline stages could fill it.
// ============================================================================
module binary_3x3_neighborhood_lut import bnl_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bnl_in_if.sink              i_in,
    bnl_out_if.source           o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    localparam int W_RST = (DIM_RESET > MAX_WIDTH)  ? MAX_WIDTH  : DIM_RESET;
    localparam int H_RST = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

    // stage 1 control: the accepted item while its line buffer word arrives
    typedef struct packed {
        logic             tbl_wr;
        logic [IDX_W-1:0] tbl_idx;
        logic [PIX_W-1:0] tbl_val;
        logic             adv;       // pixel or flush: moves the raster on
        logic             bit_in;
        logic             emit;
        logic [IDX_W-1:0] mask;
        logic             last;
    } t_s1;

    // ---------------------------------------------------------------- config
    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic          r_pad;
    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    logic          cfg_restart;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        cfg_restart = 1'b0;
        prdata      = '0;
        unique case (cfg_idx)
            REG_FRAME_WIDTH: begin
                cfg_restart = cfg_wr;
                prdata      = 32'(r_width);
            end
            REG_FRAME_HEIGHT: begin
                cfg_restart = cfg_wr;
                prdata      = 32'(r_height);
            end
            REG_PAD_BIT: begin
                prdata = 32'(r_pad);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(W_RST);
            r_height <= HW'(H_RST);
            r_pad    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  r_width  <= WW'(clamp_dim(pwdata[DIM_FIELD_W-1:0], MAX_WIDTH));
                REG_FRAME_HEIGHT: r_height <= HW'(clamp_dim(pwdata[DIM_FIELD_W-1:0], MAX_HEIGHT));
                REG_PAD_BIT:      r_pad    <= pwdata[0];
                default:          r_pad    <= r_pad;
            endcase
        end
    end

    // ---------------------------------------------------------------- stage 0
    // Accept, classify the output position, issue the line buffer read.
    logic                  in_acc;
    logic                  s0_adv;
    logic                  s0_tbl;
    logic [CW-1:0]         s0_col;
    t_pos                  s0_pos;
    logic [IDX_W-1:0]      s0_mask;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [OUTST_W-1:0]    outstanding;
    logic                  r_s1_valid;
    logic                  r_s2_valid;

    // every item in flight holds a queue slot, so the queue never overflows
    assign outstanding = OUTST_W'(fifo_count) + OUTST_W'(r_s1_valid) + OUTST_W'(r_s2_valid);
    assign i_in.ready  = outstanding < OUTST_W'(FIFO_DEPTH);
    assign in_acc      = i_in.valid && i_in.ready;

    always_comb begin
        s0_adv = 1'b0;
        s0_tbl = 1'b0;
        unique case (i_in.kind) inside
            KIND_TABLE:             s0_tbl = in_acc;
            KIND_PIXEL, KIND_FLUSH: s0_adv = in_acc;
            default:                s0_adv = 1'b0;
        endcase
        s0_mask = (s0_pos.first_row ? MASK_TOP    : '0)
                | (s0_pos.last_row  ? MASK_BOTTOM : '0)
                | (s0_pos.first_col ? MASK_LEFT   : '0)
                | (s0_pos.last_col  ? MASK_RIGHT  : '0);
    end

    bnl_raster #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_raster (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (s0_adv),
        .i_restart (cfg_restart),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_col     (s0_col),
        .o_pos     (s0_pos)
    );

    // ---------------------------------------------------------------- stage 1
    // Shift the new column into the window, write the buffer back, and look
    // up the masked window index (or write the table).
    t_s1              r_s1;
    logic [CW-1:0]    r_s1_addr;
    logic [IDX_W-1:0] r_window;
    logic [1:0]       lb_rd;
    logic [2:0]       s1_column;
    logic [IDX_W-1:0] s1_window;
    logic [IDX_W-1:0] s1_idx;
    logic             lb_wr_en;
    logic             lut_wr_en;
    logic             lut_rd_en;

    always_comb begin
        s1_column = {r_s1.bit_in, lb_rd[1], lb_rd[0]};
        s1_window = {s1_column, r_window[IDX_W-1:3]};
        s1_idx    = r_pad ? (s1_window | r_s1.mask) : (s1_window & ~r_s1.mask);
        lb_wr_en  = r_s1_valid && r_s1.adv;
        lut_wr_en = r_s1_valid && r_s1.tbl_wr;
        lut_rd_en = r_s1_valid && r_s1.adv && r_s1.emit;
    end

    always_ff @(posedge i_clk) begin
        r_s1.tbl_wr  <= s0_tbl;
        r_s1.tbl_idx <= i_in.table_index;
        r_s1.tbl_val <= i_in.table_value;
        r_s1.adv     <= s0_adv;
        r_s1.bit_in  <= (i_in.kind == KIND_PIXEL) && (i_in.pixel != '0);
        r_s1.emit    <= s0_pos.emit;
        r_s1.mask    <= s0_mask;
        r_s1.last    <= s0_pos.last;
        r_s1_addr    <= s0_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_window   <= '0;
        end else begin
            r_s1_valid <= s0_adv || s0_tbl;
            r_s2_valid <= lut_rd_en;
            if (cfg_restart) begin
                r_window <= '0;
            end else if (lb_wr_en) begin
                r_window <= (r_s1.emit && r_s1.last) ? '0 : s1_window;
            end
        end
    end

    bnl_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s0_adv),
        .i_rd_addr (s0_col),
        .i_wr_en   (lb_wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({r_s1.bit_in, lb_rd[1]}),
        .o_rd_data (lb_rd)
    );

    // ---------------------------------------------------------------- stage 2
    logic             r_s2_last;
    logic [PIX_W-1:0] lut_rd;
    t_result          s2_result;

    always_ff @(posedge i_clk) begin
        r_s2_last <= r_s1.last;
    end

    bnl_lut u_lut (
        .i_clk     (i_clk),
        .i_wr_en   (lut_wr_en),
        .i_wr_addr (r_s1.tbl_idx),
        .i_wr_data (r_s1.tbl_val),
        .i_rd_en   (lut_rd_en),
        .i_rd_addr (s1_idx),
        .o_rd_data (lut_rd)
    );

    assign s2_result.frame_last   = r_s2_last;
    assign s2_result.result_pixel = lut_rd;

    bnl_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  (s2_result),
        .o_count (fifo_count),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        outstanding <= OUTST_W'(FIFO_DEPTH))
        else $error("more transactions in flight than result queue slots");

    a_lut_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(lut_wr_en && lut_rd_en))
        else $error("table written and read in the same cycle");
`endif

endmodule

// ===== rtl/bnl_raster.sv =====
// ============================================================================
// bnl_raster
// Raster position counters and border classification of the output pixel.
// ============================================================================
module bnl_raster import bnl_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   i_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]  i_height,
    output logic [$clog2(MAX_WIDTH)-1:0]     o_col,
    output t_pos                             o_pos
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic          inner;      // output pixel is one row up, one column left
    logic          wrap;       // output pixel is the last of two rows up
    logic [RW-1:0] h_ext;
    logic          row_end;

    always_comb begin
        h_ext   = RW'(i_height);
        inner   = (r_col != '0) && (r_row != '0);
        wrap    = (r_col == '0) && (r_row > RW'(1));
        row_end = (WW'(r_col) + WW'(1)) == i_width;

        o_pos.emit      = inner || wrap;
        o_pos.first_row = (inner && r_row == RW'(1)) || (wrap && r_row == RW'(2));
        o_pos.last_row  = (inner && r_row == h_ext) || (wrap && r_row == h_ext + RW'(1));
        o_pos.first_col = (inner && r_col == CW'(1)) || (wrap && i_width == WW'(1));
        o_pos.last_col  = wrap;
        o_pos.last      = wrap && (r_row == h_ext + RW'(1));
        o_col           = r_col;

        n_row = r_row;
        n_col = r_col;
        if (i_restart) begin
            n_row = '0;
            n_col = '0;
        end else if (i_adv) begin
            if (o_pos.last) begin
                n_row = '0;
                n_col = '0;
            end else if (row_end) begin
                n_row = r_row + RW'(1);
                n_col = '0;
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

`ifndef SYNTHESIS
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h_ext + RW'(1))
        else $error("raster row ran past the drain row");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_pos.last) |=> (r_row == '0 && r_col == '0))
        else $error("counters not cleared after last pixel of frame");
`endif

endmodule

// ===== rtl/bnl_line_buf.sv =====
// ============================================================================
// bnl_line_buf
// Per-column store of the two previous rows' bits, with write forwarding.
// ============================================================================
module bnl_line_buf import bnl_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_wr_addr,
    input  logic [1:0]                    i_wr_data,
    output logic [1:0]                    o_rd_data
);
    // entry bit 1: row above, bit 0: two rows above
    logic [1:0] r_mem [MAX_WIDTH];
    logic [1:0] r_rd_data;
    logic [1:0] r_fwd_data;
    logic       r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        r_fwd_data <= i_wr_data;
    end

    // same column read and written at one edge (single-column frames)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_rd_en && i_wr_en && (i_rd_addr == i_wr_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

`ifndef SYNTHESIS
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && i_wr_en && i_rd_addr == i_wr_addr) |=> (o_rd_data == $past(i_wr_data)))
        else $error("colliding line buffer read missed the fresh write");
`endif

endmodule

// ===== rtl/bnl_lut.sv =====
// ============================================================================
// bnl_lut
// 512 x 8 lookup table memory with registered read data.
// ============================================================================
module bnl_lut import bnl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  logic [PIX_W-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output logic [PIX_W-1:0]  o_rd_data
);
    logic [PIX_W-1:0] r_mem [TABLE_DEPTH];
    logic [PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bnl_out_fifo.sv =====
// ============================================================================
// bnl_out_fifo
// Small result queue that decouples the pipeline from the output stall.
// ============================================================================
module bnl_out_fifo import bnl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  t_result                i_data,
    output logic [FIFO_CNT_W-1:0]  o_count,
    bnl_out_if.source              o_out
);
    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop;

    assign pop                = o_out.valid && o_out.ready;
    assign o_out.valid        = (r_count != '0);
    assign o_out.result_pixel = r_mem[r_rd_ptr].result_pixel;
    assign o_out.frame_last   = r_mem[r_rd_ptr].frame_last;
    assign o_count            = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sim/tb_binary_3x3_neighborhood_lut.sv =====
// ============================================================================
// tb_binary_3x3_neighborhood_lut
// Self-checking regression for the streaming 3x3 binary neighbourhood lookup.
// A built-in raster predictor (line bits, window, counters, table image)
// forecasts every output transaction. The stimulus loads the whole table,
// reads back the reset and saturated geometry, walks a short directed plan,
// runs narrow and wide single frames and then random frames with idling,
// back-pressure and broken sequences. All of it goes through the APB port
// and the two streams.
// ============================================================================
module tb_binary_3x3_neighborhood_lut import bnl_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W             = DEF_MAX_WIDTH;
    localparam int MAX_H             = DEF_MAX_HEIGHT;
    localparam int IDLE_PCT          = 21;      // idle chance per cycle, each side
    localparam int HOLD_CYCLES       = 200;     // long receiver stall, fills the block
    localparam int SETTLE_CYCLES     = 8;       // pipeline is two stages deep
    localparam int RANDOM_ITEMS      = 240;
    localparam int MIN_PHASES        = 10;
    // Slowest correct run is under a thousand transactions with idling and a
    // full queue, plus the stall, settle and register pauses; the limit is
    // many times that.
    localparam int CYCLE_LIMIT       = 100000;
    localparam int NUM_PLAN          = 40;

    // kind 3 is not a named kind in the package; the block drops it
    localparam logic [1:0] KIND_DROP = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [PIX_W-1:0] pixel;
        logic [IDX_W-1:0] table_index;
        logic [PIX_W-1:0] table_value;
    } t_in_item;

    typedef enum logic [1:0] {STEP_ITEM, STEP_REG, STEP_READ} t_step;

    typedef struct {
        t_step       op;
        t_in_item    item;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;   // value written, or value expected on a read
        bit          typed;     // expected result written into the plan
        t_result     want;
    } t_plan_row;

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    always #6 i_clk = ~i_clk;

    bnl_in_if  in_if ();
    bnl_out_if out_if ();

    binary_3x3_neighborhood_lut #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the geometry, the table and the
    // raster. Line bits start at zero; only border-masked positions ever see
    // a bit that was not written in the current frame, so any start works.
    // ------------------------------------------------------------------------
    bit [PIX_W-1:0] lut_image [TABLE_DEPTH];
    bit             line_bits [2*MAX_W];
    logic [IDX_W-1:0] win = '0;
    int             row_pos = 0;
    int             col_pos = 0;
    int             geo_w   = MAX_W;
    int             geo_h   = MAX_H;
    bit             geo_pad = 1'b0;

    t_result        awaited_results [$];

    // run statistics and control shared between processes
    int  cycle_count = 0;
    int  n_errors    = 0;
    int  n_items     = 0;
    int  n_random    = 0;
    int  n_results   = 0;
    int  n_frames    = 0;
    bit  counting    = 1'b0;
    bit  calm        = 1'b0;    // no idling on either side
    bit  hold_pending = 1'b0;   // request for one long receiver stall
    bit  pause_between_frames = 1'b0;

    t_plan_row plan [NUM_PLAN];

    // zero reads as one, anything above the bound sits at the bound
    function automatic int fit_dim(input logic [DIM_FIELD_W-1:0] v, input int bound);
        if (v == '0) return 1;
        return (int'(v) > bound) ? bound : int'(v);
    endfunction

    function automatic void restart_raster();
        row_pos = 0;
        col_pos = 0;
        win     = '0;
    endfunction

    // Advance the predicted raster by one transaction; returns 1 with the
    // forecast in res when the transaction completes an output neighbourhood.
    function automatic bit classify_item(input t_in_item it, output t_result res);
        bit               px;
        bit               emit;
        int               slot_old, slot_mid, cr, cc;
        logic [2:0]       column;
        logic [IDX_W-1:0] border, idx;
        res    = '0;
        emit   = 1'b0;
        cr     = 0;
        cc     = 0;
        border = '0;
        if (it.kind == KIND_TABLE) begin
            lut_image[it.table_index] = it.table_value;
            return 1'b0;
        end
        if (it.kind == KIND_DROP) return 1'b0;

        // a flush, inside or after the frame, shifts in a clear bit
        px = (it.kind == KIND_PIXEL) && (it.pixel != '0);

        // new column: two rows up, one row up, this row; parity picks the slot
        slot_old = (row_pos % 2) * geo_w + col_pos;
        slot_mid = ((row_pos + 1) % 2) * geo_w + col_pos;
        column   = {px, line_bits[slot_mid], line_bits[slot_old]};
        line_bits[slot_old] = px;
        win = {column, win[IDX_W-1:3]};

        // output position trails the input by one row and one column
        if (col_pos >= 1 && row_pos >= 1) begin
            emit = 1'b1;
            cr   = row_pos - 1;
            cc   = col_pos - 1;
        end else if (col_pos == 0 && row_pos >= 2) begin
            emit = 1'b1;
            cr   = row_pos - 2;
            cc   = geo_w - 1;
        end
        col_pos++;
        if (col_pos >= geo_w) begin
            col_pos = 0;
            row_pos++;
        end
        if (!emit) return 1'b0;

        if (cr == 0)         border |= MASK_TOP;
        if (cr == geo_h - 1) border |= MASK_BOTTOM;
        if (cc == 0)         border |= MASK_LEFT;
        if (cc == geo_w - 1) border |= MASK_RIGHT;
        idx = geo_pad ? (win | border) : (win & ~border);

        res.result_pixel = lut_image[idx];
        res.frame_last   = (cr == geo_h - 1) && (cc == geo_w - 1);
        if (res.frame_last) restart_raster();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Plan row builders
    // ------------------------------------------------------------------------
    function automatic t_plan_row row_item(input logic [1:0] kind, input logic [7:0] pix,
                                           input logic [8:0] tidx, input logic [7:0] tval);
        t_plan_row r;
        r.op      = STEP_ITEM;
        r.item    = '{kind: kind, pixel: pix, table_index: tidx, table_value: tval};
        r.reg_idx = '0;
        r.reg_val = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic t_plan_row row_reg(input logic [1:0] idx, input logic [31:0] val);
        t_plan_row r;
        r         = row_item(KIND_FLUSH, '0, '0, '0);
        r.op      = STEP_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // register readback with the value typed in
    function automatic t_plan_row row_read(input logic [1:0] idx, input logic [31:0] val);
        t_plan_row r;
        r       = row_reg(idx, val);
        r.op    = STEP_READ;
        r.typed = 1'b1;
        return r;
    endfunction

    function automatic t_plan_row row_hit(input logic [1:0] kind, input logic [7:0] pix,
                                          input logic [7:0] res_px, input logic res_last);
        t_plan_row r;
        r       = row_item(kind, pix, '0, '0);
        r.typed = 1'b1;
        r.want  = '{frame_last: res_last, result_pixel: res_px};
        return r;
    endfunction

    // every field random, then the kind forced
    function automatic t_in_item noise_item(input logic [1:0] kind);
        t_in_item it;
        it.kind        = kind;
        it.pixel       = PIX_W'($urandom_range(255));
        it.table_index = IDX_W'($urandom_range(TABLE_DEPTH - 1));
        it.table_value = PIX_W'($urandom_range(255));
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. Inputs move on the falling edge, handshakes are judged on the
    // rising edge.
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        n_errors++;
    endtask

    task automatic send_item(input t_in_item it, input bit typed = 1'b0,
                             input t_result typed_res = '0);
        t_result res;
        bit      hit;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid       <= 1'b1;
        in_if.kind        <= it.kind;
        in_if.pixel       <= it.pixel;
        in_if.table_index <= it.table_index;
        in_if.table_value <= it.table_value;
        do @(posedge i_clk); while (!in_if.ready);
        n_items++;
        if (counting && it.kind != KIND_DROP) n_random++;
        hit = classify_item(it, res);
        if (typed) begin
            awaited_results.push_back(typed_res);
        end else if (hit) begin
            awaited_results.push_back(res);
        end
    endtask

    // lower valid, let every forecast arrive, then let the pipeline empty
    task automatic quiesce_stream();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write, setup then access; unused high data bits carry noise
    task automatic write_reg(input logic [1:0] reg_idx, input int unsigned raw);
        logic [31:0] data;
        data = $urandom();
        if (reg_idx == REG_PAD_BIT) begin
            data[0] = raw[0];
        end else begin
            data[DIM_FIELD_W-1:0] = raw[DIM_FIELD_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (reg_idx)
            REG_FRAME_WIDTH: begin
                geo_w = fit_dim(data[DIM_FIELD_W-1:0], MAX_W);
                restart_raster();
            end
            REG_FRAME_HEIGHT: begin
                geo_h = fit_dim(data[DIM_FIELD_W-1:0], MAX_H);
                restart_raster();
            end
            REG_PAD_BIT: geo_pad = data[0];
            default: ;
        endcase
    endtask

    // APB read, setup then access; prdata is taken at the access edge
    task automatic read_reg(input logic [1:0] reg_idx, input logic [31:0] want);
        logic [31:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) flag_mismatch("register readback", got, want);
    endtask

    // One frame of random content. When noisy: dropped kinds and table
    // rewrites are sprinkled in, a few frames are abandoned part way and a
    // few are drained short so that the next frame's pixels finish the drain.
    task automatic run_frame(input bit noisy);
        int       n_px, cut, drain, density;
        t_in_item it;
        n_px    = geo_w * geo_h;
        cut     = n_px;
        drain   = geo_w + 1;
        density = $urandom_range(100);
        if (noisy && $urandom_range(99) < 8) cut = $urandom_range(n_px - 1);
        if (noisy && $urandom_range(99) < 8) drain = $urandom_range(geo_w);
        for (int i = 0; i < cut; i++) begin
            if (noisy && $urandom_range(99) < 4) send_item(noise_item(KIND_DROP));
            if (noisy && $urandom_range(99) < 3) send_item(noise_item(KIND_TABLE));
            it = noise_item(($urandom_range(99) < 5) ? KIND_FLUSH : KIND_PIXEL);
            if (it.kind == KIND_PIXEL) begin
                it.pixel = ($urandom_range(99) < density) ? PIX_W'($urandom_range(1, 255)) : '0;
            end
            send_item(it);
        end
        if (cut < n_px) begin
            // abandoned frame: rewriting the width restarts the raster
            quiesce_stream();
            write_reg(REG_FRAME_WIDTH, geo_w);
        end else begin
            for (int i = 0; i < drain; i++) begin
                send_item(noise_item(($urandom_range(99) < 20) ? KIND_PIXEL : KIND_FLUSH));
            end
        end
    endtask

    task automatic run_phase(input int unsigned w_raw, input int unsigned h_raw,
                             input int frames, input bit noisy);
        quiesce_stream();
        write_reg(REG_FRAME_WIDTH, w_raw);
        write_reg(REG_FRAME_HEIGHT, h_raw);
        write_reg(REG_PAD_BIT, $urandom_range(1));
        for (int f = 0; f < frames; f++) begin
            if (pause_between_frames && f > 0) quiesce_stream();
            run_frame(noisy);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random idling, plus one long stall on request, counted here
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_left    = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // every output transaction is matched against the oldest forecast
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch("unexpected result_pixel", out_if.result_pixel, 0);
            end else begin
                want = awaited_results.pop_front();
                if (out_if.result_pixel !== want.result_pixel)
                    flag_mismatch("result_pixel", out_if.result_pixel, want.result_pixel);
                if (out_if.frame_last !== want.frame_last)
                    flag_mismatch("frame_last", out_if.frame_last, want.frame_last);
                n_results++;
                if (want.frame_last) n_frames++;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("binary_3x3_neighborhood_lut regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned w_raw, h_raw;
        int          phase;
        int          n_frm;

        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.kind        = KIND_FLUSH;
        in_if.pixel       = '0;
        in_if.table_index = '0;
        in_if.table_value = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;

        // Reset values and saturation are read back first. Then 1x1 frames
        // give results that read straight off the table entries for an
        // all-clear index, a lone centre bit, all-padded and padded with a
        // clear centre; a 2x1 frame then takes a flush mid-frame.
        plan = '{
            row_read(REG_FRAME_WIDTH, MAX_W),       // geometry after reset
            row_read(REG_FRAME_HEIGHT, MAX_H),
            row_read(REG_PAD_BIT, 0),
            row_reg(REG_FRAME_WIDTH, 12'hFFF),      // above the maximum
            row_read(REG_FRAME_WIDTH, MAX_W),
            row_reg(REG_FRAME_HEIGHT, 12'hFFF),
            row_read(REG_FRAME_HEIGHT, MAX_H),
            row_reg(REG_FRAME_WIDTH, 0),            // zero width reads as one
            row_read(REG_FRAME_WIDTH, 1),
            row_reg(REG_FRAME_HEIGHT, 0),
            row_read(REG_FRAME_HEIGHT, 1),
            row_reg(REG_PAD_BIT, 0),
            row_item(KIND_TABLE, 8'h00, 9'h000, 8'h5A),
            row_item(KIND_TABLE, 8'h00, 9'h1FF, 8'hA5),
            row_item(KIND_TABLE, 8'h00, 9'h010, 8'h3C),
            row_item(KIND_TABLE, 8'h00, 9'h1EF, 8'hC3),
            row_item(KIND_DROP, 8'hFF, 9'h1FF, 8'hFF),   // dropped, no transaction out
            row_item(KIND_PIXEL, 8'h00, '0, '0),
            row_item(KIND_FLUSH, 8'h00, '0, '0),
            row_hit(KIND_FLUSH, 8'h00, 8'h5A, 1'b1),
            row_item(KIND_PIXEL, 8'hFF, '0, '0),
            row_item(KIND_FLUSH, 8'h00, '0, '0),
            row_hit(KIND_FLUSH, 8'h00, 8'h3C, 1'b1),     // centre bit alone
            row_reg(REG_PAD_BIT, 1),
            row_item(KIND_PIXEL, 8'h01, '0, '0),
            row_item(KIND_FLUSH, 8'h00, '0, '0),
            row_hit(KIND_FLUSH, 8'h00, 8'hA5, 1'b1),     // every bit set
            row_item(KIND_PIXEL, 8'h00, '0, '0),
            row_item(KIND_FLUSH, 8'hFF, '0, '0),         // flush ignores its pixel
            row_hit(KIND_FLUSH, 8'h00, 8'hC3, 1'b1),
            row_item(KIND_PIXEL, 8'h00, '0, '0),
            row_item(KIND_PIXEL, 8'hFF, '0, '0),         // pixel while draining
            row_hit(KIND_PIXEL, 8'h80, 8'hC3, 1'b1),
            row_reg(REG_FRAME_WIDTH, 2),
            row_reg(REG_FRAME_HEIGHT, 1),
            row_item(KIND_PIXEL, 8'h80, '0, '0),
            row_item(KIND_FLUSH, 8'h7F, '0, '0),         // flush inside the frame
            row_item(KIND_FLUSH, 8'h00, '0, '0),
            row_item(KIND_FLUSH, 8'h00, '0, '0),
            row_item(KIND_FLUSH, 8'h00, '0, '0)
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // whole table first, so no result ever reads an unwritten entry
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_item('{kind: KIND_TABLE, pixel: '0, table_index: IDX_W'(i),
                        table_value: PIX_W'($urandom_range(255))});
        end

        foreach (plan[i]) begin
            case (plan[i].op)
                STEP_REG: begin
                    quiesce_stream();
                    write_reg(plan[i].reg_idx, plan[i].reg_val);
                end
                STEP_READ: begin
                    quiesce_stream();
                    read_reg(plan[i].reg_idx, plan[i].reg_val);
                end
                default: begin
                    send_item(plan[i].item, plan[i].typed, plan[i].want);
                end
            endcase
        end

        // single-column frame, then a wider single row
        run_phase(1, 6, 1, 1'b0);
        run_phase(16, 1, 1, 1'b0);

        // random geometries: mostly tiny frames, now and then a wider one
        counting = 1'b1;
        phase    = 0;
        while (n_random < RANDOM_ITEMS || phase < MIN_PHASES) begin
            w_raw = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
            h_raw = $urandom_range(0, 5);
            n_frm = $urandom_range(1, 2);
            calm  = (phase >= 4 && phase <= 7);
            pause_between_frames = (phase == 9);
            if (phase == 1) begin
                // long receiver stall on a big enough frame to back up the input;
                // wait for the earlier results so the stall lands on this frame
                w_raw        = 8;
                h_raw        = 6;
                n_frm        = 1;
                quiesce_stream();
                hold_pending = 1'b1;
            end
            run_phase(w_raw, h_raw, n_frm, 1'b1);
            phase++;
        end
        calm = 1'b0;
        pause_between_frames = 1'b0;

        quiesce_stream();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d input transactions (%0d random) over %0d random geometries,",
                 n_items, n_random, phase);
        $display("%0d results checked across %0d finished frames; reset and saturated sizes read back.",
                 n_results, n_frames);
        if (n_errors == 0 && awaited_results.size() == 0) begin
            $display("binary_3x3_neighborhood_lut regression: pass");
        end else begin
            $display("binary_3x3_neighborhood_lut regression: fail");
        end
        $finish;
    end

endmodule
